/* rtl/hesd_pkg.sv */
// ----------------------------------------------------------------------------
// hesd_pkg: shared types, constants and tables of the entity decoder
// Character codes, the named entity table, the numeric code point map and
// the control and status groups exchanged between decoder modules.
// ----------------------------------------------------------------------------
package hesd_pkg;

   // held name characters
   localparam int NAME_MAX = 15;
   localparam int CNT_W    = $clog2(NAME_MAX + 1);
   localparam int IDX_W    = $clog2(NAME_MAX);

   // named entity table geometry
   localparam int CMP_LEN  = 6;   // longest entity name
   localparam int ENT_NUM  = 15;
   localparam int SEL_W    = $clog2(ENT_NUM);
   localparam int REP_MAX  = 3;   // longest replacement
   localparam int REP_W    = $clog2(REP_MAX + 1);

   // numeric accumulator
   localparam int          VAL_W    = 21;
   localparam int          PROD_W   = VAL_W + 4;
   localparam logic [VAL_W-1:0] CODE_SAT = 21'h110000;

   // character codes
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_LOW_X = 8'h78;

   typedef logic [CMP_LEN-1:0][7:0] head_type;  // element 0 is the first char
   typedef logic [REP_MAX-1:0][7:0] rep_type;   // element 0 goes out first

   typedef struct packed {
      logic             hit;
      logic [SEL_W-1:0] sel;
   } lookup_type;

   // sequencer to numeric unit
   typedef struct packed {
      logic clear;
      logic step;
      logic hex;
   } num_ctrl_type;

   // numeric unit to sequencer
   typedef struct packed {
      logic       digit_ok;
      logic [7:0] code_char;
   } num_stat_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_HASH;
   endfunction

   // c is already lower case
   function automatic digit_type digit_value(input logic [7:0] c, input logic hex);
      digit_type d;
      d = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.ok    = 1'b1;
         d.value = 4'(c - 8'h30);
      end else if (hex && c >= 8'h61 && c <= 8'h66) begin
         d.ok    = 1'b1;
         d.value = 4'(c - 8'h57);
      end
      return d;
   endfunction

   // code point to output byte
   function automatic logic [7:0] map_code(input logic [VAL_W-1:0] v);
      logic [7:0] c;
      if (v == VAL_W'(32'hA0))                                c = CH_SPACE;
      else if (v >= VAL_W'(32) && v < VAL_W'(128))            c = v[7:0];
      else if (v == VAL_W'(32'h2018) || v == VAL_W'(32'h2019)) c = CH_APOS;
      else if (v == VAL_W'(32'h201C) || v == VAL_W'(32'h201D)) c = CH_QUOTE;
      else if (v == VAL_W'(32'h2013) || v == VAL_W'(32'h2014)) c = CH_DASH;
      else                                                     c = CH_QUEST;
      return c;
   endfunction

   // entity names, written last character first
   function automatic head_type ent_name(input logic [SEL_W-1:0] sel);
      head_type n;
      unique case (sel)
         4'd0:    n = head_type'("pma");
         4'd1:    n = head_type'("tl");
         4'd2:    n = head_type'("tg");
         4'd3:    n = head_type'("touq");
         4'd4:    n = head_type'("sopa");
         4'd5:    n = head_type'("psbn");
         4'd6:    n = head_type'("ypoc");
         4'd7:    n = head_type'("ger");
         4'd8:    n = head_type'("hsadm");
         4'd9:    n = head_type'("hsadn");
         4'd10:   n = head_type'("pilleh");
         4'd11:   n = head_type'("ouqsr");
         4'd12:   n = head_type'("ouqsl");
         4'd13:   n = head_type'("ouqdr");
         4'd14:   n = head_type'("ouqdl");
         default: n = '0;
      endcase
      return n;
   endfunction

   function automatic logic [CNT_W-1:0] ent_name_len(input logic [SEL_W-1:0] sel);
      logic [CNT_W-1:0] l;
      unique case (sel)
         4'd1, 4'd2:                          l = CNT_W'(2);
         4'd0, 4'd7:                          l = CNT_W'(3);
         4'd3, 4'd4, 4'd5, 4'd6:              l = CNT_W'(4);
         4'd8, 4'd9, 4'd11, 4'd12, 4'd13, 4'd14: l = CNT_W'(5);
         4'd10:                               l = CNT_W'(6);
         default:                             l = '0;
      endcase
      return l;
   endfunction

   // replacement text, written last character first
   function automatic rep_type ent_rep(input logic [SEL_W-1:0] sel);
      rep_type r;
      unique case (sel)
         4'd0:              r = rep_type'(CH_AMP);
         4'd1:              r = rep_type'(8'h3C);
         4'd2:              r = rep_type'(8'h3E);
         4'd3, 4'd13, 4'd14: r = rep_type'(CH_QUOTE);
         4'd4, 4'd11, 4'd12: r = rep_type'(CH_APOS);
         4'd5:              r = rep_type'(CH_SPACE);
         4'd6:              r = rep_type'(")c(");
         4'd7:              r = rep_type'(")r(");
         4'd8, 4'd9:        r = rep_type'(CH_DASH);
         4'd10:             r = rep_type'("...");
         default:           r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [REP_W-1:0] ent_rep_len(input logic [SEL_W-1:0] sel);
      return (sel == 4'd6 || sel == 4'd7 || sel == 4'd10) ? REP_W'(3) : REP_W'(1);
   endfunction

   // case-insensitive match of the held name against the table
   function automatic lookup_type ent_lookup(input head_type head,
                                             input logic [CNT_W-1:0] cnt);
      lookup_type res;
      head_type   nm;
      logic       eq;
      res = '0;
      for (int e = 0; e < ENT_NUM; e++) begin
         nm = ent_name(SEL_W'(e));
         eq = (cnt == ent_name_len(SEL_W'(e)));
         for (int i = 0; i < CMP_LEN; i++) begin
            if (CNT_W'(i) < cnt && to_lower(head[i]) != nm[i]) begin
               eq = 1'b0;
            end
         end
         if (eq && !res.hit) begin
            res.hit = 1'b1;
            res.sel = SEL_W'(e);
         end
      end
      return res;
   endfunction

endpackage

/* rtl/hesd_name_store.sv */
// ----------------------------------------------------------------------------
// hesd_name_store: held entity name characters
// One write port at the fill position, one read port for replay and digit
// scan, and the leading characters exposed at fixed places for name lookup.
// ----------------------------------------------------------------------------
module hesd_name_store (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [hesd_pkg::IDX_W-1:0] wr_idx,
   input  logic [7:0]               wr_data,
   input  logic [hesd_pkg::IDX_W-1:0] rd_idx,
   output logic [7:0]               rd_data,
   output hesd_pkg::head_type       head
);

   logic [7:0] store_ff [hesd_pkg::NAME_MAX];

   // write at fill position
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= wr_data;
      end
   end

   // replay / scan read
   assign rd_data = (rd_idx < hesd_pkg::IDX_W'(hesd_pkg::NAME_MAX)) ?
                    store_ff[rd_idx] : '0;

   // leading characters for the lookup
   always_comb begin
      for (int i = 0; i < hesd_pkg::CMP_LEN; i++) begin
         head[i] = store_ff[i];
      end
   end

endmodule

/* rtl/hesd_num_unit.sv */
// ----------------------------------------------------------------------------
// hesd_num_unit: shared numeric entity accumulator
// Takes one digit per step, multiplies the running value by 10 or 16, adds
// the digit and saturates; maps the final value to an output byte.
// ----------------------------------------------------------------------------
module hesd_num_unit (
   input  logic                    clock,
   input  hesd_pkg::num_ctrl_type  ctrl,
   input  logic [7:0]              char_in,
   output hesd_pkg::num_stat_type  stat
);

   logic [hesd_pkg::VAL_W-1:0]  acc_ff;
   logic [hesd_pkg::VAL_W-1:0]  acc_in;
   logic [hesd_pkg::PROD_W-1:0] acc_wide;
   logic [hesd_pkg::PROD_W-1:0] scaled;
   logic [hesd_pkg::PROD_W-1:0] sum;
   hesd_pkg::digit_type         dig;

   assign dig      = hesd_pkg::digit_value(hesd_pkg::to_lower(char_in), ctrl.hex);
   assign acc_wide = hesd_pkg::PROD_W'(acc_ff);

   // times 16 or times 10 by shifts
   assign scaled = ctrl.hex ? (acc_wide << 4) : ((acc_wide << 3) + (acc_wide << 1));
   assign sum    = scaled + hesd_pkg::PROD_W'(dig.value);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.step && dig.ok) begin
         acc_in = (sum > hesd_pkg::PROD_W'(hesd_pkg::CODE_SAT)) ?
                  hesd_pkg::CODE_SAT : sum[hesd_pkg::VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign stat.digit_ok  = dig.ok;
   assign stat.code_char = hesd_pkg::map_code(acc_ff);

endmodule

/* rtl/html_entity_stream_decoder.sv */
// A plain byte is loaded into the rsp output register when it is taken if that is free, else from CHAR;
// plain bytes flow one per cycle while rsp is not stalled. Name characters are stored with no output.
// A named entity sends its replacement bytes from NAMED; a numeric one steps the shared accumulator
// once per digit in NUM and sends its byte from NUMOUT; a literal flush replays from FLUSH.
// req_tready is low while the sequencer is outside IDLE.
// Reset (synchronous, active high) returns to plain text mode with no pending output.
// ----------------------------------------------------------------------------
// html_entity_stream_decoder: streaming HTML character entity decoder
// Passes text bytes through, collects entity names after '&', and on ';'
// decodes named or numeric entities (unknown names are dropped); abandoned entities are replayed.
// ----------------------------------------------------------------------------
module html_entity_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast    // run_last
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FLUSH  = 6'b000010,
      ST_CHAR   = 6'b000100,
      ST_NUM    = 6'b001000,
      ST_NUMOUT = 6'b010000,
      ST_NAMED  = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   logic                             in_ent_ff, in_ent_in;
   logic [hesd_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [hesd_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [7:0]                       byte_ff, byte_in;
   logic                             eot_ff, eot_in;
   logic                             aft_plain_ff, aft_plain_in;
   logic                             aft_open_ff, aft_open_in;
   logic                             hex_ff, hex_in;
   logic [hesd_pkg::SEL_W-1:0]       sel_ff, sel_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             accept;
   logic                             slot_free;
   logic                             out_load;
   logic [7:0]                       out_char;
   logic                             out_last;
   logic                             is_store, is_dec, is_flush, is_open, is_plain;
   logic                             hex_now;
   logic                             flush_done;
   logic                             wr_en;
   logic [hesd_pkg::IDX_W-1:0]       rd_idx;
   logic [hesd_pkg::CNT_W-1:0]       rd_pos;
   logic [7:0]                       rd_data;
   hesd_pkg::head_type               head;
   hesd_pkg::lookup_type             look;
   hesd_pkg::rep_type                rep;
   hesd_pkg::num_ctrl_type           num_ctrl;
   hesd_pkg::num_stat_type           num_stat;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // classify the incoming byte against the entity state
   always_comb begin
      is_store = in_ent_ff && hesd_pkg::is_name_char(req_tdata) &&
                 cnt_ff < hesd_pkg::CNT_W'(hesd_pkg::NAME_MAX);
      is_dec   = in_ent_ff && !is_store && req_tdata == hesd_pkg::CH_SEMI &&
                 cnt_ff != '0;
      is_flush = in_ent_ff && !is_store && !is_dec;
      is_open  = !is_store && !is_dec && req_tdata == hesd_pkg::CH_AMP;
      is_plain = !is_store && !is_dec && req_tdata != hesd_pkg::CH_AMP;
   end

   assign hex_now = cnt_ff >= hesd_pkg::CNT_W'(2) &&
                    hesd_pkg::to_lower(head[1]) == hesd_pkg::CH_LOW_X;
   assign look    = hesd_pkg::ent_lookup(head, cnt_ff);
   assign rep     = hesd_pkg::ent_rep(sel_ff);

   // store read: replay reads one behind the '&', digit scan reads in place
   assign rd_pos = (state_ff == ST_FLUSH) ? idx_ff - hesd_pkg::CNT_W'(1) : idx_ff;
   assign rd_idx = rd_pos[hesd_pkg::IDX_W-1:0];
   assign wr_en  = accept && is_store;

   hesd_name_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (cnt_ff[hesd_pkg::IDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .head    (head)
   );

   hesd_num_unit u_num (
      .clock   (clock),
      .ctrl    (num_ctrl),
      .char_in (rd_data),
      .stat    (num_stat)
   );

   assign flush_done = (idx_ff == cnt_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      in_ent_in    = in_ent_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      eot_in       = eot_ff;
      aft_plain_in = aft_plain_ff;
      aft_open_in  = aft_open_ff;
      hex_in       = hex_ff;
      sel_in       = sel_ff;
      out_load     = 1'b0;
      out_char     = byte_ff;
      out_last     = 1'b1;
      num_ctrl     = '0;
      num_ctrl.hex = hex_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               byte_in      = req_tdata;
               eot_in       = req_tlast;
               idx_in       = '0;
               aft_plain_in = 1'b0;
               aft_open_in  = 1'b0;
               priority if (is_store) begin
                  cnt_in = cnt_ff + hesd_pkg::CNT_W'(1);
                  if (req_tlast) begin
                     state_in = ST_FLUSH;
                  end
               end else if (is_dec) begin
                  if (head[0] == hesd_pkg::CH_HASH) begin
                     hex_in         = hex_now;
                     idx_in         = hex_now ? hesd_pkg::CNT_W'(2) : hesd_pkg::CNT_W'(1);
                     num_ctrl.clear = 1'b1;
                     state_in       = ST_NUM;
                  end else if (look.hit) begin
                     sel_in   = look.sel;
                     state_in = ST_NAMED;
                  end else begin
                     in_ent_in = 1'b0;
                     cnt_in    = '0;
                  end
               end else if (is_flush) begin
                  aft_plain_in = is_plain;
                  aft_open_in  = is_open;
                  state_in     = ST_FLUSH;
               end else if (is_open) begin
                  in_ent_in = 1'b1;
                  cnt_in    = '0;
                  if (req_tlast) begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  // plain byte straight to the output when the slot allows
                  if (slot_free) begin
                     out_load = 1'b1;
                     out_char = req_tdata;
                  end else begin
                     state_in = ST_CHAR;
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (slot_free) begin
               out_load = 1'b1;
               out_char = (idx_ff == '0) ? hesd_pkg::CH_AMP : rd_data;
               out_last = flush_done && !aft_plain_ff && !(aft_open_ff && eot_ff);
               if (!flush_done) begin
                  idx_in = idx_ff + hesd_pkg::CNT_W'(1);
               end else begin
                  cnt_in    = '0;
                  in_ent_in = 1'b0;
                  idx_in    = '0;
                  priority if (aft_plain_ff) begin
                     state_in = ST_CHAR;
                  end else if (aft_open_ff && eot_ff) begin
                     // reopened entity closed at once by end of text
                     aft_open_in = 1'b0;
                  end else if (aft_open_ff) begin
                     in_ent_in = 1'b1;
                     state_in  = ST_IDLE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         ST_CHAR: begin
            if (slot_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_NUM: begin
            if (idx_ff < cnt_ff && num_stat.digit_ok) begin
               num_ctrl.step = 1'b1;
               idx_in        = idx_ff + hesd_pkg::CNT_W'(1);
            end else begin
               state_in = ST_NUMOUT;
            end
         end

         ST_NUMOUT: begin
            if (slot_free) begin
               out_load  = 1'b1;
               out_char  = num_stat.code_char;
               in_ent_in = 1'b0;
               cnt_in    = '0;
               state_in  = ST_IDLE;
            end
         end

         ST_NAMED: begin
            if (slot_free) begin
               out_load = 1'b1;
               out_char = rep[idx_ff[hesd_pkg::REP_W-1:0]];
               out_last = (idx_ff[hesd_pkg::REP_W-1:0] ==
                           hesd_pkg::ent_rep_len(sel_ff) - hesd_pkg::REP_W'(1));
               if (out_last) begin
                  in_ent_in = 1'b0;
                  cnt_in    = '0;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in = idx_ff + hesd_pkg::CNT_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_char_in  = out_load ? out_char : rsp_char_ff;
   assign rsp_last_in  = out_load ? out_last : rsp_last_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_ent_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_ent_ff    <= in_ent_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      byte_ff      <= byte_in;
      eot_ff       <= eot_in;
      aft_plain_ff <= aft_plain_in;
      aft_open_ff  <= aft_open_in;
      hex_ff       <= hex_in;
      sel_ff       <= sel_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/hesd_checker.sv */
// ----------------------------------------------------------------------------
// hesd_checker: port-level checks of the entity decoder
// Watches the request and response channels and flags handshake and
// sequencing errors; attached to the top level by bind.
// ----------------------------------------------------------------------------
module hesd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled response transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // reset leaves no response pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // while a run is unfinished no new request transaction is taken
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken inside an unfinished run");

   // '&' at end of text always flushes, so the input must stall
   a_amp_eot: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && req_tdata == hesd_pkg::CH_AMP
      |=> !req_tready)
      else $error("no flush after ampersand at end of text");

endmodule

bind html_entity_stream_decoder hesd_checker u_hesd_checker (.*);
